// ----- sv/tfol_pkg.sv -----
// shared types, widths and register codes for the three-axis low-pass filter
package tfol_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 26;
    localparam int COEF_FRAC = 24;
    localparam int OUT_FRAC  = 16;
    localparam int ZONEG_W   = 15;
    localparam int HIST_W    = SAMPLE_W + 2 + OUT_FRAC;
    localparam int ACC_W     = COEF_W + HIST_W + 2;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [COEF_W-1:0] COEF_CURRENT_RST  = 26'sd328965;
    localparam logic signed [COEF_W-1:0] COEF_PREV_IN_RST  = 26'sd328965;
    localparam logic signed [COEF_W-1:0] COEF_PREV_OUT_RST = -26'sd16119286;
    localparam logic [ZONEG_W-1:0]       Z_ONE_G_RST       = 15'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_CURRENT  = 2'd0,
        CFG_COEF_PREV_IN  = 2'd1,
        CFG_COEF_PREV_OUT = 2'd2,
        CFG_Z_ONE_G       = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_x;
        logic signed [SAMPLE_W-1:0] filtered_y;
        logic signed [SAMPLE_W-1:0] filtered_z;
        logic                       priming_pass;
    } result_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_current;
        logic signed [COEF_W-1:0] coef_prev_in;
        logic signed [COEF_W-1:0] coef_prev_out;
        logic [ZONEG_W-1:0]       z_one_g;
    } coef_t;

endpackage

// ----- sv/tfol_cfg.sv -----
// configuration register bank: filter coefficients and z axis start value
module tfol_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  tfol_pkg::cfg_idx_t                 cfg_index,
    input  logic [tfol_pkg::COEF_W-1:0]        cfg_data,
    output tfol_pkg::coef_t                    coef
);

    tfol_pkg::coef_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.coef_current  <= tfol_pkg::COEF_CURRENT_RST;
            coef_reg.coef_prev_in  <= tfol_pkg::COEF_PREV_IN_RST;
            coef_reg.coef_prev_out <= tfol_pkg::COEF_PREV_OUT_RST;
            coef_reg.z_one_g       <= tfol_pkg::Z_ONE_G_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tfol_pkg::CFG_COEF_CURRENT:  coef_reg.coef_current  <= cfg_data;
                tfol_pkg::CFG_COEF_PREV_IN:  coef_reg.coef_prev_in  <= cfg_data;
                tfol_pkg::CFG_COEF_PREV_OUT: coef_reg.coef_prev_out <= cfg_data;
                tfol_pkg::CFG_Z_ONE_G:
                    coef_reg.z_one_g <= cfg_data[tfol_pkg::ZONEG_W-1:0];
                default: ;
            endcase
        end
    end

    assign coef = coef_reg;

endmodule

// ----- sv/tfol_axis.sv -----
// one axis of the filter: history registers and the multiply-accumulate datapath
module tfol_axis
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic                                 prime,
    input  logic signed [tfol_pkg::SAMPLE_W-1:0] x,
    input  logic signed [tfol_pkg::SAMPLE_W-1:0] prime_val,
    input  tfol_pkg::coef_t                      coef,
    output logic signed [tfol_pkg::SAMPLE_W-1:0] y
);

    localparam int SW   = tfol_pkg::SAMPLE_W;
    localparam int CW   = tfol_pkg::COEF_W;
    localparam int HW   = tfol_pkg::HIST_W;
    localparam int AW   = tfol_pkg::ACC_W;
    localparam int CF   = tfol_pkg::COEF_FRAC;
    localparam int OF   = tfol_pkg::OUT_FRAC;
    localparam int PW   = CW + SW;
    localparam int QW   = AW - CF;
    localparam int IW   = HW - OF;

    localparam logic signed [AW-1:0] ACC_ADJ  = {{(AW-CF){1'b0}}, {CF{1'b1}}};
    localparam logic signed [HW-1:0] HIST_ADJ = {{(HW-OF){1'b0}}, {OF{1'b1}}};
    localparam logic signed [HW-1:0] HIST_MAX = {1'b0, {(HW-1){1'b1}}};
    localparam logic signed [HW-1:0] HIST_MIN = {1'b1, {(HW-1){1'b0}}};
    localparam logic signed [SW-1:0] OUT_MAX  = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] OUT_MIN  = {1'b1, {(SW-1){1'b0}}};

    logic signed [SW-1:0] last_in_reg;
    logic signed [HW-1:0] last_out_reg;

    logic signed [CW-1:0] c_cur;
    logic signed [CW-1:0] c_pin;
    logic signed [CW-1:0] c_pout;
    logic signed [PW-1:0] p_cur;
    logic signed [PW-1:0] p_pin;
    logic signed [CW+HW-1:0] p_pout;
    logic signed [PW:0]   in_sum;
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] acc_adj;
    logic signed [QW-1:0] q;
    logic                 q_ovf;
    logic signed [HW-1:0] y_hist;
    logic signed [HW-1:0] h_adj;
    logic signed [IW-1:0] y_int;
    logic                 y_ovf;

    assign c_cur  = coef.coef_current;
    assign c_pin  = coef.coef_prev_in;
    assign c_pout = coef.coef_prev_out;

    // three products, all independent
    assign p_cur  = c_cur * x;
    assign p_pin  = c_pin * last_in_reg;
    assign p_pout = c_pout * last_out_reg;

    assign in_sum = (PW+1)'(p_cur) + (PW+1)'(p_pin);
    assign acc    = (AW'(in_sum) <<< OF) - AW'(p_pout);

    // shift toward zero, then clamp to the history range
    assign acc_adj = acc + (acc[AW-1] ? ACC_ADJ : '0);
    assign q       = acc_adj[AW-1:CF];
    assign q_ovf   = !((&q[QW-1:HW-1]) || !(|q[QW-1:HW-1]));
    assign y_hist  = q_ovf ? (q[QW-1] ? HIST_MIN : HIST_MAX) : q[HW-1:0];

    // integer part toward zero, clamped to the sample range
    assign h_adj = y_hist + (y_hist[HW-1] ? HIST_ADJ : '0);
    assign y_int = h_adj[HW-1:OF];
    assign y_ovf = !((&y_int[IW-1:SW-1]) || !(|y_int[IW-1:SW-1]));
    assign y     = y_ovf ? (y_int[IW-1] ? OUT_MIN : OUT_MAX) : y_int[SW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_in_reg  <= '0;
            last_out_reg <= '0;
        end
        else if (load)
        begin
            if (prime)
            begin
                last_in_reg  <= prime_val;
                last_out_reg <= {{(HW-SW-OF){prime_val[SW-1]}}, prime_val, {OF{1'b0}}};
            end
            else
            begin
                last_in_reg  <= x;
                last_out_reg <= y_hist;
            end
        end
    end

endmodule

// ----- sv/three_axis_first_order_lowpass.sv -----
// three-axis first-order low-pass filter, top level
// path: a transferred sample waits in the input stage, then moves to the result stage
// throughput: one sample per cycle when not stalled, set by the history update in each axis
//   (three multiplies, accumulate, shift and clamp between input stage and history)
// reset: coefficients return to defaults, history clears, and the first sample
//   after reset is echoed with priming_pass set while it loads the start history
module three_axis_first_order_lowpass
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  tfol_pkg::sample_t                 sample,
    output logic                              result_valid,
    input  logic                              result_stall,
    output tfol_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [tfol_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tfol_pkg::COEF_W-1:0]       cfg_data
);

    localparam int SW = tfol_pkg::SAMPLE_W;
    localparam int ZW = tfol_pkg::ZONEG_W;

    tfol_pkg::coef_t   coef;

    // input stage
    logic              in_valid_reg;
    tfol_pkg::sample_t in_data_reg;

    // result stage
    logic              res_valid_reg;
    tfol_pkg::result_t res_data_reg;
    tfol_pkg::result_t res_data_next;

    // cleared by reset, set once the priming sample moves to the result stage
    logic              primed_reg;

    logic              sample_xfer;
    logic              advance;
    logic signed [SW-1:0] z_start;
    logic signed [SW-1:0] fx;
    logic signed [SW-1:0] fy;
    logic signed [SW-1:0] fz;

    tfol_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (tfol_pkg::cfg_idx_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // the input stage moves on whenever the result stage is empty or being drained
    assign advance      = in_valid_reg && (!res_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && !advance;
    assign sample_xfer  = sample_valid && !sample_stall;

    // z history starts at the 1 g reading, x and y at zero
    assign z_start = {{(SW-ZW){1'b0}}, coef.z_one_g};

    tfol_axis u_axis_x
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .prime     (!primed_reg),
        .x         (in_data_reg.sample_x),
        .prime_val ('0),
        .coef      (coef),
        .y         (fx)
    );

    tfol_axis u_axis_y
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .prime     (!primed_reg),
        .x         (in_data_reg.sample_y),
        .prime_val ('0),
        .coef      (coef),
        .y         (fy)
    );

    tfol_axis u_axis_z
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .prime     (!primed_reg),
        .x         (in_data_reg.sample_z),
        .prime_val (z_start),
        .coef      (coef),
        .y         (fz)
    );

    // priming pass echoes the raw sample
    always_comb
    begin
        if (!primed_reg)
        begin
            res_data_next.filtered_x   = in_data_reg.sample_x;
            res_data_next.filtered_y   = in_data_reg.sample_y;
            res_data_next.filtered_z   = in_data_reg.sample_z;
            res_data_next.priming_pass = 1'b1;
        end
        else
        begin
            res_data_next.filtered_x   = fx;
            res_data_next.filtered_y   = fy;
            res_data_next.filtered_z   = fz;
            res_data_next.priming_pass = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
        end
        else
        begin
            if (sample_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                primed_reg    <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            in_data_reg <= sample;
        end
        if (advance)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_data_reg;

`ifndef SYNTHESIS
    // no filtered result may exist before the priming pass
    a_no_result_unprimed: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> !result_valid)
        else $error("result present before priming pass");

    // only the very first result after reset is a priming pass
    a_prime_once: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && primed_reg) |=> !result.priming_pass)
        else $error("priming pass repeated");

    // the input side only stalls while the input stage holds a sample
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> in_valid_reg)
        else $error("stall with empty input stage");

    // a sample that moves on always shows up as a result
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("advanced sample lost");
`endif

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the three-axis first-order low-pass filter
`timescale 1ns / 1ps

module tb_top;

    // run length guard, far above the slowest correct run
    localparam int CYCLE_LIMIT = 200000;
    // results pass through the input stage and the result stage after the sample transfer
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PRINT_CAP = 40;
    localparam int SW = tfol_pkg::SAMPLE_W;
    localparam int CW = tfol_pkg::COEF_W;
    localparam int ZW = tfol_pkg::ZONEG_W;
    localparam longint OUT_SCALE = longint'(1) <<< tfol_pkg::OUT_FRAC;

    // idling per random phase: none, sender only, receiver only, both
    localparam int SEND_PCT [4] = '{0, 71, 0, 32};
    localparam int STALL_PCT [4] = '{0, 0, 71, 32};

    // coefficient sets for the directed rows
    localparam tfol_pkg::coef_t DIR_COEFS [4] = '{
        // defaults, z history starting at its top value
        '{tfol_pkg::COEF_CURRENT_RST, tfol_pkg::COEF_PREV_IN_RST,
          tfol_pkg::COEF_PREV_OUT_RST, 15'd32767},
        // everything zero, output must collapse to zero
        '{'0, '0, '0, 15'd0},
        // max weights with most negative feedback weight, runs into saturation
        '{26'h1FFFFFF, 26'h1FFFFFF, 26'h2000000, 15'd0},
        // mirror of the above
        '{26'h2000000, 26'h2000000, 26'h1FFFFFF, 15'd32767}
    };

    typedef struct packed {
        logic [1:0]        coef_set;
        logic              typed;
        tfol_pkg::sample_t stim;
        tfol_pkg::result_t want;
    } dir_row_t;

    // directed stimulus, expected value typed in only where it is obvious
    localparam int DIR_ROWS = 17;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // first sample after reset is echoed untouched
        '{2'd0, 1'b1, '{16'sh8000, 16'sh7FFF, 16'sh1234},
                      '{16'sh8000, 16'sh7FFF, 16'sh1234, 1'b1}},
        '{2'd0, 1'b0, '{16'sh0000, 16'sh0000, 16'sh0000}, '0},
        '{2'd0, 1'b0, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, '0},
        '{2'd0, 1'b0, '{16'sh8000, 16'sh8000, 16'sh8000}, '0},
        '{2'd0, 1'b0, '{16'sh5555, 16'shAAAA, 16'sh00FF}, '0},
        '{2'd0, 1'b0, '{16'shAAAA, 16'sh5555, 16'shFF00}, '0},
        '{2'd0, 1'b0, '{16'sd100, -16'sd100, 16'sd512}, '0},
        // zero weights
        '{2'd1, 1'b1, '{16'sh7FFF, 16'sh8000, 16'sh0001}, '0},
        '{2'd1, 1'b1, '{16'shFFFF, 16'sh0001, 16'sh0000}, '0},
        // positive runaway: output clamps, then the history clamps
        '{2'd2, 1'b0, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, '0},
        '{2'd2, 1'b1, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
                      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0}},
        '{2'd2, 1'b1, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
                      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0}},
        '{2'd2, 1'b0, '{16'sh8000, 16'sh8000, 16'sh8000}, '0},
        '{2'd2, 1'b0, '{16'sh0000, 16'sh0000, 16'sh0000}, '0},
        // sign-swapped weights on a saturated history
        '{2'd3, 1'b0, '{16'sh8000, 16'sh8000, 16'sh8000}, '0},
        '{2'd3, 1'b0, '{16'sh8000, 16'sh8000, 16'sh8000}, '0},
        '{2'd3, 1'b0, '{16'sh0001, 16'shFFFF, 16'sh0000}, '0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_stall;
    tfol_pkg::sample_t sample;
    logic              result_valid;
    logic              result_stall;
    tfol_pkg::result_t result;
    logic              cfg_we;
    logic [tfol_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [CW-1:0]     cfg_data;

    // filter state as the bench sees it
    tfol_pkg::coef_t   coef_now;
    bit                primed;
    longint            hist_in [3];
    longint            hist_out [3];
    tfol_pkg::result_t filtered_due [$];

    logic signed [SW-1:0] held [3];
    int send_pct;
    int stall_pct;
    int mismatch_count;
    int result_count;
    int cycle_count;

    three_axis_first_order_lowpass i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shift right with truncation toward zero
    function automatic longint trunc_shift(input longint v, input int sh);
        if (v < 0)
            return -((-v) >>> sh);
        return v >>> sh;
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // filtered result for one sample transfer; advances the history
    function automatic tfol_pkg::result_t next_filtered(input tfol_pkg::sample_t s);
        tfol_pkg::result_t r;
        longint  x [3];
        longint  acc;
        longint  y;
        logic signed [SW-1:0] y16 [3];
        int k;
        r = '0;
        if (!primed)
        begin
            // priming pass: echo, then load the start history
            r.filtered_x   = s.sample_x;
            r.filtered_y   = s.sample_y;
            r.filtered_z   = s.sample_z;
            r.priming_pass = 1'b1;
            hist_in[0]  = 0;
            hist_in[1]  = 0;
            hist_in[2]  = longint'(coef_now.z_one_g);
            hist_out[0] = 0;
            hist_out[1] = 0;
            hist_out[2] = hist_in[2] * OUT_SCALE;
            primed = 1'b1;
            return r;
        end
        x[0] = longint'($signed(s.sample_x));
        x[1] = longint'($signed(s.sample_y));
        x[2] = longint'($signed(s.sample_z));
        for (k = 0; k < 3; k++)
        begin
            acc = longint'($signed(coef_now.coef_current)) * x[k] * OUT_SCALE
                + longint'($signed(coef_now.coef_prev_in)) * hist_in[k] * OUT_SCALE
                - longint'($signed(coef_now.coef_prev_out)) * hist_out[k];
            y = clamp(trunc_shift(acc, tfol_pkg::COEF_FRAC), tfol_pkg::HIST_W);
            hist_in[k]  = x[k];
            hist_out[k] = y;
            y16[k] = SW'(clamp(trunc_shift(y, tfol_pkg::OUT_FRAC), SW));
        end
        r.filtered_x = y16[0];
        r.filtered_y = y16[1];
        r.filtered_z = y16[2];
        return r;
    endfunction

    function automatic logic [CW-1:0] corner_coef();
        case ($urandom_range(3))
            0:       return 26'h2000000;
            1:       return 26'h1FFFFFF;
            2:       return '0;
            default: return CW'($urandom);
        endcase
    endfunction

    // coefficient styles: defaults, unity-gain low-pass, anything, corners
    function automatic tfol_pkg::coef_t draw_coefs(input int style);
        tfol_pkg::coef_t c;
        int a;
        c.z_one_g = ZW'($urandom);
        case (style)
            0:
            begin
                c.coef_current  = tfol_pkg::COEF_CURRENT_RST;
                c.coef_prev_in  = tfol_pkg::COEF_PREV_IN_RST;
                c.coef_prev_out = tfol_pkg::COEF_PREV_OUT_RST;
            end
            1:
            begin
                // c1 = c2 = a, c3 = 2a - 1.0 gives unit gain at dc
                a = int'($urandom_range(1 << 23));
                c.coef_current  = CW'(a);
                c.coef_prev_in  = CW'(a);
                c.coef_prev_out = CW'(2 * a - (1 << tfol_pkg::COEF_FRAC));
            end
            2:
            begin
                c.coef_current  = CW'($urandom);
                c.coef_prev_in  = CW'($urandom);
                c.coef_prev_out = CW'($urandom);
            end
            default:
            begin
                c.coef_current  = corner_coef();
                c.coef_prev_in  = corner_coef();
                c.coef_prev_out = corner_coef();
            end
        endcase
        return c;
    endfunction

    // mix of full-range noise, small values, extremes and a slow random walk
    function automatic tfol_pkg::sample_t draw_sample();
        tfol_pkg::sample_t s;
        logic signed [SW-1:0] ax [3];
        int kind;
        int k;
        kind = int'($urandom_range(9));
        for (k = 0; k < 3; k++)
        begin
            case (kind)
                0, 1, 2, 3: ax[k] = SW'($urandom);
                4, 5:       ax[k] = SW'(int'($urandom_range(1023)) - 512);
                6:
                    case ($urandom_range(3))
                        0:       ax[k] = 16'sh8000;
                        1:       ax[k] = 16'sh7FFF;
                        2:       ax[k] = 16'sh0000;
                        default: ax[k] = 16'shFFFF;
                    endcase
                default:    ax[k] = held[k] + SW'(int'($urandom_range(64)) - 32);
            endcase
            held[k] = ax[k];
        end
        s.sample_x = ax[0];
        s.sample_y = ax[1];
        s.sample_z = ax[2];
        return s;
    endfunction

    // register writes, one per edge; only called with the filter idle
    task automatic load_coefs(input tfol_pkg::coef_t c);
        tfol_pkg::cfg_idx_t idx;
        logic [CW-1:0] val;
        int k;
        for (k = 0; k < 4; k++)
        begin
            idx = tfol_pkg::cfg_idx_t'(k);
            case (idx)
                tfol_pkg::CFG_COEF_CURRENT:  val = c.coef_current;
                tfol_pkg::CFG_COEF_PREV_IN:  val = c.coef_prev_in;
                tfol_pkg::CFG_COEF_PREV_OUT: val = c.coef_prev_out;
                tfol_pkg::CFG_Z_ONE_G:       val = {{(CW - ZW){1'b0}}, c.z_one_g};
                default:                     val = '0;
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        coef_now = c;
    endtask

    // one sample transfer with random idle cycles ahead of it
    task automatic send_sample(input tfol_pkg::sample_t stim, input logic typed,
                               input tfol_pkg::result_t typed_want);
        tfol_pkg::result_t predicted;
        while ($urandom_range(99) < send_pct)
        begin
            // payload is free to wander while valid is low
            sample_valid <= 1'b0;
            sample       <= tfol_pkg::sample_t'({$urandom, 16'($urandom)});
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= stim;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        // transfer happened at this edge
        predicted = next_filtered(stim);
        filtered_due.push_back(typed ? typed_want : predicted);
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (filtered_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ERROR: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [SW-1:0] got,
                               input logic [SW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %h expected %h",
                                      result_count, name, got, want));
    endtask

    // receiver stall, redrawn every cycle
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    // result checker: one transfer per edge, compared with the oldest expectation
    always @(posedge clk)
    begin
        tfol_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (filtered_due.size() == 0)
                report_mismatch($sformatf("result %h with no sample outstanding", result));
            else
            begin
                want = filtered_due.pop_front();
                check_field("filtered_x", result.filtered_x, want.filtered_x);
                check_field("filtered_y", result.filtered_y, want.filtered_y);
                check_field("filtered_z", result.filtered_z, want.filtered_z);
                check_field("priming_pass", SW'(result.priming_pass),
                            SW'(want.priming_pass));
            end
            result_count++;
        end
    end

    // hard stop
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** three_axis_first_order_lowpass: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int cur_set;
        int i;
        int phase;
        int n;
        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        sample         = '0;
        result_stall   = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_pct       = 0;
        stall_pct      = 0;
        mismatch_count = 0;
        result_count   = 0;
        cycle_count    = 0;
        primed         = 1'b0;
        coef_now       = '{tfol_pkg::COEF_CURRENT_RST, tfol_pkg::COEF_PREV_IN_RST,
                           tfol_pkg::COEF_PREV_OUT_RST, tfol_pkg::Z_ONE_G_RST};
        for (i = 0; i < 3; i++)
        begin
            hist_in[i]  = 0;
            hist_out[i] = 0;
            held[i]     = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; a new coefficient set waits for the filter to go idle
        cur_set = -1;
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (int'(DIR_TAB[i].coef_set) != cur_set)
            begin
                wait_drained();
                cur_set = int'(DIR_TAB[i].coef_set);
                load_coefs(DIR_COEFS[cur_set]);
            end
            send_sample(DIR_TAB[i].stim, DIR_TAB[i].typed, DIR_TAB[i].want);
        end

        // random phases, each with its own idling and two coefficient settings
        for (phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            send_pct  = SEND_PCT[phase];
            stall_pct = STALL_PCT[phase];
            load_coefs(draw_coefs(phase));
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                begin
                    // sender holds off until the pipe is empty, then retunes
                    wait_drained();
                    load_coefs(draw_coefs((phase + 1) % 4));
                end
                send_sample(draw_sample(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** three_axis_first_order_lowpass: PASSED **");
        else
            $display("** three_axis_first_order_lowpass: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/tfol_pkg.sv
sv/tfol_cfg.sv
sv/tfol_axis.sv
sv/three_axis_first_order_lowpass.sv
bench/tb_top.sv
